FILE: hdl/refcounted_slot_allocator_defines.svh
// Assertion macros for the reference-counted slot allocator.
// Included by the top level; needs clk and arst_n in the including scope.
`ifndef REFCOUNTED_SLOT_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define RSA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RSA_ASSERT_IMPL(lbl, ante, cons, msg)
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/rsa_pkg.sv
// Shared constants, codes and interface types of the slot allocator.
// Used by rsa_ctrl, rsa_dpath and refcounted_slot_allocator.
package rsa_pkg;

	// Table geometry.
	localparam int SLOTS      = 256;
	localparam int COUNT_BITS = 8;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HW_W       = $clog2(SLOTS + 1);

	// Free-slot search: the busy map is split into groups of GROUP_W bits.
	localparam int GROUP_W = 16;
	localparam int BIT_W   = 4;
	localparam int GRP_N   = (SLOTS + GROUP_W - 1) / GROUP_W;
	localparam int GRP_W   = (GRP_N > 1) ? $clog2(GRP_N) : 1;
	localparam int PAD_W   = GRP_N * GROUP_W;

	// Port widths.
	localparam int OP_W     = 2;
	localparam int KIND_W   = 4;
	localparam int SLOT_W   = 8;
	localparam int TYPE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int HWP_W    = 9;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SLOT_W:0]       SLOT_LIM  = (SLOT_W + 1)'(SLOTS);

	// Operations.
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	// Operand kinds.
	localparam logic [KIND_W-1:0] KIND_TEMP      = 4'd0;
	localparam logic [KIND_W-1:0] KIND_LAST_KNOWN = 4'd8;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STS_YES   = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NO    = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BAD   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_FULL  = 3'd3;
	localparam logic [STATUS_W-1:0] STS_NOREL = 3'd4;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SCAN_GRP = 7'b0000010,
		S_SCAN_BIT = 7'b0000100,
		S_ALLOC    = 7'b0001000,
		S_UPDATE   = 7'b0010000,
		S_FINISH   = 7'b0100000,
		S_SPARE    = 7'b1000000
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic scan_grp;
		logic scan_bit;
		logic alloc;
		logic update;
		logic load_out;
	} cmd_t;

	// Datapath to controller, decoded from the input fields.
	typedef struct packed {
		logic in_alloc;
		logic in_rmw;
	} sts_t;

endpackage

FILE: hdl/rsa_ctrl.sv
// Sequencer of the slot allocator: one-hot state machine and output valid.
// Depends on rsa_pkg; drives the datapath rsa_dpath through cmd_t.
module rsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rsa_pkg::sts_t sts,
	output rsa_pkg::cmd_t cmd
);

	rsa_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			rsa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (sts.in_alloc) begin
						state_nxt = rsa_pkg::S_SCAN_GRP;
					end else if (sts.in_rmw) begin
						state_nxt = rsa_pkg::S_UPDATE;
					end else begin
						state_nxt = rsa_pkg::S_FINISH;
					end
				end
			end
			rsa_pkg::S_SCAN_GRP: begin
				cmd.scan_grp = 1'b1;
				state_nxt    = rsa_pkg::S_SCAN_BIT;
			end
			rsa_pkg::S_SCAN_BIT: begin
				cmd.scan_bit = 1'b1;
				state_nxt    = rsa_pkg::S_ALLOC;
			end
			rsa_pkg::S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_nxt = rsa_pkg::S_FINISH;
			end
			rsa_pkg::S_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = rsa_pkg::S_FINISH;
			end
			rsa_pkg::S_FINISH: begin
				// Wait for the output register to be free.
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = rsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = rsa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsa_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hdl/rsa_dpath.sv
// Datapath of the slot allocator: busy map, count memory, free-slot search,
// count update and output register. Depends on rsa_pkg; controlled by rsa_ctrl.
module rsa_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rsa_pkg::cmd_t                  cmd,
	output rsa_pkg::sts_t                  sts,
	input  logic [rsa_pkg::OP_W-1:0]       op,
	input  logic [rsa_pkg::KIND_W-1:0]     operand_kind,
	input  logic [rsa_pkg::SLOT_W-1:0]     slot_index,
	input  logic [rsa_pkg::TYPE_W-1:0]     value_type,
	output logic [rsa_pkg::STATUS_W-1:0]   status,
	output logic [rsa_pkg::SLOT_W-1:0]     granted_slot,
	output logic [rsa_pkg::TYPE_W-1:0]     granted_type,
	output logic [rsa_pkg::HWP_W-1:0]      high_water
);

	// Captured request.
	logic [rsa_pkg::OP_W-1:0]   op_q;
	logic [rsa_pkg::IDX_W-1:0]  slot_q;
	logic [rsa_pkg::TYPE_W-1:0] vtype_q;

	// Slot state: one busy bit per slot; the count memory holds valid data
	// only for busy slots.
	logic [rsa_pkg::SLOTS-1:0]      busy_q;
	logic [rsa_pkg::HW_W-1:0]       high_mark_q;
	logic [rsa_pkg::COUNT_BITS-1:0] count_mem [rsa_pkg::SLOTS];
	logic [rsa_pkg::COUNT_BITS-1:0] rd_q;

	// Search pipeline.
	logic [rsa_pkg::PAD_W-1:0]   busy_pad;
	logic [rsa_pkg::GRP_N-1:0]   grp_free, grp_free_s1;
	logic [rsa_pkg::GRP_W-1:0]   grp_sel, grp_sel_s2;
	logic                        grp_found, grp_found_s2;
	logic [rsa_pkg::GROUP_W-1:0] grp_bits;
	logic [rsa_pkg::BIT_W-1:0]   bit_sel;
	logic [rsa_pkg::GRP_W+rsa_pkg::BIT_W-1:0] alloc_full;
	logic [rsa_pkg::IDX_W-1:0]   alloc_slot;
	logic [rsa_pkg::HW_W-1:0]    alloc_mark;

	// Count update.
	logic                           upd_busy;
	logic [rsa_pkg::COUNT_BITS-1:0] upd_count;
	logic                           upd_zero;
	logic                           in_range;

	// Result and output registers.
	logic [rsa_pkg::STATUS_W-1:0] res_status_q, status_q;
	logic [rsa_pkg::SLOT_W-1:0]   res_slot_q, granted_slot_q;
	logic [rsa_pkg::TYPE_W-1:0]   res_type_q, granted_type_q;
	logic [rsa_pkg::HWP_W-1:0]    high_water_q;

	// Status of requests that need neither a search nor a count update.
	function automatic logic [rsa_pkg::STATUS_W-1:0] quick_status(
		input logic [rsa_pkg::OP_W-1:0]   f_op,
		input logic [rsa_pkg::KIND_W-1:0] f_kind
	);
		logic [rsa_pkg::STATUS_W-1:0] s;
		s = rsa_pkg::STS_BAD;
		if (f_op == rsa_pkg::OP_ACQUIRE) begin
			if (f_kind != rsa_pkg::KIND_TEMP) begin
				s = rsa_pkg::STS_NO;
			end
		end else if (f_op == rsa_pkg::OP_RELEASE) begin
			if (f_kind > rsa_pkg::KIND_LAST_KNOWN) begin
				s = rsa_pkg::STS_NOREL;
			end else if (f_kind != rsa_pkg::KIND_TEMP) begin
				s = rsa_pkg::STS_NO;
			end
		end
		return s;
	endfunction

	assign in_range     = {1'b0, slot_index} < rsa_pkg::SLOT_LIM;
	assign sts.in_alloc = (op == rsa_pkg::OP_ALLOC);
	assign sts.in_rmw   = ((op == rsa_pkg::OP_ACQUIRE) || (op == rsa_pkg::OP_RELEASE)) &&
		(operand_kind == rsa_pkg::KIND_TEMP) && in_range;

	// Padding beyond the table reads as busy so it is never granted.
	for (genvar i = 0; i < rsa_pkg::PAD_W; i++) begin : g_pad
		if (i < rsa_pkg::SLOTS) begin : g_real
			assign busy_pad[i] = busy_q[i];
		end else begin : g_fill
			assign busy_pad[i] = 1'b1;
		end
	end

	for (genvar g = 0; g < rsa_pkg::GRP_N; g++) begin : g_grp
		assign grp_free[g] = ~&busy_pad[g*rsa_pkg::GROUP_W +: rsa_pkg::GROUP_W];
	end

	// Lowest group holding a free slot.
	always_comb begin
		grp_sel   = '0;
		grp_found = 1'b0;
		for (int g = rsa_pkg::GRP_N - 1; g >= 0; g--) begin
			if (grp_free_s1[g]) begin
				grp_sel   = rsa_pkg::GRP_W'(g);
				grp_found = 1'b1;
			end
		end
	end

	// Lowest free slot within the chosen group.
	assign grp_bits = busy_pad[{grp_sel_s2, rsa_pkg::BIT_W'(0)} +: rsa_pkg::GROUP_W];

	always_comb begin
		bit_sel = '0;
		for (int b = rsa_pkg::GROUP_W - 1; b >= 0; b--) begin
			if (!grp_bits[b]) begin
				bit_sel = rsa_pkg::BIT_W'(b);
			end
		end
	end

	assign alloc_full = {grp_sel_s2, bit_sel};
	assign alloc_slot = alloc_full[rsa_pkg::IDX_W-1:0];
	assign alloc_mark = rsa_pkg::HW_W'(alloc_slot) + rsa_pkg::HW_W'(1);

	// Read-modify-write of a held count.
	assign upd_busy = busy_q[slot_q];
	always_comb begin
		if (op_q == rsa_pkg::OP_ACQUIRE) begin
			upd_count = (rd_q == rsa_pkg::COUNT_MAX) ? rd_q :
				rd_q + rsa_pkg::COUNT_BITS'(1);
		end else begin
			upd_count = rd_q - rsa_pkg::COUNT_BITS'(1);
		end
	end
	assign upd_zero = (upd_count == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			high_mark_q <= '0;
		end else begin
			if (cmd.alloc && grp_found_s2) begin
				busy_q[alloc_slot] <= 1'b1;
				if (alloc_mark > high_mark_q) begin
					high_mark_q <= alloc_mark;
				end
			end
			if (cmd.update && upd_busy && upd_zero) begin
				busy_q[slot_q] <= 1'b0;
			end
		end
	end

	// Count memory: one write port, registered read at capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q <= count_mem[slot_index[rsa_pkg::IDX_W-1:0]];
		end
		if (cmd.alloc && grp_found_s2) begin
			count_mem[alloc_slot] <= rsa_pkg::COUNT_BITS'(1);
		end else if (cmd.update && upd_busy && !upd_zero) begin
			count_mem[slot_q] <= upd_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q         <= op;
			slot_q       <= slot_index[rsa_pkg::IDX_W-1:0];
			vtype_q      <= value_type;
			res_status_q <= quick_status(op, operand_kind);
			res_slot_q   <= '0;
			res_type_q   <= '0;
		end
		if (cmd.scan_grp) begin
			grp_free_s1 <= grp_free;
		end
		if (cmd.scan_bit) begin
			grp_sel_s2   <= grp_sel;
			grp_found_s2 <= grp_found;
		end
		if (cmd.alloc) begin
			if (grp_found_s2) begin
				res_status_q <= rsa_pkg::STS_YES;
				res_slot_q   <= rsa_pkg::SLOT_W'(alloc_slot);
				res_type_q   <= vtype_q;
			end else begin
				res_status_q <= rsa_pkg::STS_FULL;
			end
		end
		if (cmd.update) begin
			if (!upd_busy) begin
				res_status_q <= rsa_pkg::STS_BAD;
			end else if ((op_q == rsa_pkg::OP_ACQUIRE) || upd_zero) begin
				res_status_q <= rsa_pkg::STS_YES;
			end else begin
				res_status_q <= rsa_pkg::STS_NO;
			end
		end
	end

	// Output register, cleared by reset so the reported mark starts at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q       <= '0;
			granted_slot_q <= '0;
			granted_type_q <= '0;
			high_water_q   <= '0;
		end else if (cmd.load_out) begin
			status_q       <= res_status_q;
			granted_slot_q <= res_slot_q;
			granted_type_q <= res_type_q;
			high_water_q   <= rsa_pkg::HWP_W'(high_mark_q);
		end
	end

	assign status       = status_q;
	assign granted_slot = granted_slot_q;
	assign granted_type = granted_type_q;
	assign high_water   = high_water_q;

endmodule

FILE: hdl/refcounted_slot_allocator.sv
// Reference-counted slot allocator, top level. Allocate walks the three-step
// free-slot search; acquire/release of a temporary operand reads the count at
// acceptance and writes it back; other requests go straight to the result.
// A new request is taken only once the last result is in the output register.
// Reset (arst_n, asynchronous) frees every slot and zeroes the high-water mark.
`include "refcounted_slot_allocator_defines.svh"

module refcounted_slot_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rsa_pkg::OP_W-1:0]     op,
	input  logic [rsa_pkg::KIND_W-1:0]   operand_kind,
	input  logic [rsa_pkg::SLOT_W-1:0]   slot_index,
	input  logic [rsa_pkg::TYPE_W-1:0]   value_type,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rsa_pkg::STATUS_W-1:0] status,
	output logic [rsa_pkg::SLOT_W-1:0]   granted_slot,
	output logic [rsa_pkg::TYPE_W-1:0]   granted_type,
	output logic [rsa_pkg::HWP_W-1:0]    high_water
);

	// The controller walks one transaction at a time through its states; the
	// datapath holds the busy map (one flip-flop per slot, cleared by reset),
	// the count memory, whose entries are trusted only where the busy bit is
	// set, and an output register so a finished result can wait for the sink
	// while the next request is already accepted.
	rsa_pkg::cmd_t cmd;
	rsa_pkg::sts_t sts;

	rsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The search for the lowest free slot runs in three registered steps:
	// an any-free flag per group of sixteen slots, the lowest such group,
	// then the lowest free slot inside it. Acquire and release read the
	// count when the transaction is accepted and write it back in the cycle after.
	rsa_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.operand_kind (operand_kind),
		.slot_index   (slot_index),
		.value_type   (value_type),
		.status       (status),
		.granted_slot (granted_slot),
		.granted_type (granted_type),
		.high_water   (high_water)
	);

	// Only one transaction is in flight: no new one right after an acceptance.
	`RSA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
		"second request taken while busy")

	// A full table can only be reported once every slot has been handed out.
	`RSA_ASSERT_IMPL(a_full_mark, out_valid && (status == rsa_pkg::STS_FULL),
		(high_water == rsa_pkg::HWP_W'(rsa_pkg::SLOTS)) && (granted_slot == '0),
		"full reported below table size")

	// The high-water mark never falls.
	`RSA_ASSERT_NEXT(a_mark_monotonic, 1'b1, high_water >= $past(high_water),
		"high-water mark decreased")

	// A grant carrying a nonzero type always lies below the reported high-water mark.
	`RSA_ASSERT_IMPL(a_grant_below_mark,
		out_valid && (status == rsa_pkg::STS_YES) && (granted_type != '0),
		rsa_pkg::HWP_W'(granted_slot) < high_water,
		"granted slot above high-water mark")

	// At most one command is issued at a time, so capture never coincides with work.
	`RSA_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd),
		"controller issued two commands at once")

endmodule

FILE: verif/rsa_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the slot allocator testbench: a cycle-free copy of the slot
// table that predicts each grant, and the queue of grants still awaited.
// Depends on rsa_pkg for widths, operation codes and status codes.
package rsa_tb_pkg;
	import rsa_pkg::*;

	// Codes the block's package does not name.
	localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
	localparam logic [KIND_W-1:0] KIND_ARG     = 4'd1;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd9;
	localparam logic [KIND_W-1:0] KIND_UNUSED  = 4'd10;
	localparam logic [KIND_W-1:0] KIND_TOP     = 4'd15;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [TYPE_W-1:0]   vtype;
		logic [HWP_W-1:0]    hw;
	} grant_t;

	class alloc_scoreboard;
		logic [COUNT_BITS-1:0] use_cnt [SLOTS];
		logic [HWP_W-1:0]      hw_mark;
		logic [SLOT_W-1:0]     last_slot;
		grant_t                expected_grants [$];
		int                    errors;
		int                    status_hits [5];
		int                    saturated;

		function new();
			foreach (use_cnt[i]) use_cnt[i] = '0;
			foreach (status_hits[i]) status_hits[i] = 0;
			hw_mark   = '0;
			last_slot = '0;
			errors    = 0;
			saturated = 0;
		endfunction

		function bit table_full();
			foreach (use_cnt[i]) begin
				if (use_cnt[i] == '0) return 1'b0;
			end
			return 1'b1;
		endfunction

		// Applies one request to the table copy and returns the grant it yields.
		function grant_t predict_grant(logic [OP_W-1:0] req_op, logic [KIND_W-1:0] kind,
				logic [SLOT_W-1:0] slot, logic [TYPE_W-1:0] vtype);
			grant_t g;
			bit     found;
			g     = '0;
			found = 1'b0;
			case (req_op)
				OP_ALLOC: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (!found && use_cnt[i] == '0) begin
							found      = 1'b1;
							use_cnt[i] = COUNT_BITS'(1);
							if (i + 1 > int'(hw_mark)) hw_mark = HWP_W'(i + 1);
							last_slot  = SLOT_W'(i);
							g.status   = STS_YES;
							g.slot     = SLOT_W'(i);
							g.vtype    = vtype;
						end
					end
					if (!found) g.status = STS_FULL;
				end
				OP_ACQUIRE: begin
					if (kind != KIND_TEMP) begin
						g.status = STS_NO;
					end else if (int'(slot) >= SLOTS || use_cnt[slot] == '0) begin
						g.status = STS_BAD;
					end else begin
						// A count at its ceiling stays there, yet the acquire succeeds.
						if (use_cnt[slot] != COUNT_MAX) use_cnt[slot] = use_cnt[slot] + 1'b1;
						else saturated++;
						g.status = STS_YES;
					end
				end
				OP_RELEASE: begin
					if (kind != KIND_TEMP) begin
						g.status = (kind <= KIND_LAST_KNOWN) ? STS_NO : STS_NOREL;
					end else if (int'(slot) >= SLOTS || use_cnt[slot] == '0) begin
						g.status = STS_BAD;
					end else begin
						use_cnt[slot] = use_cnt[slot] - 1'b1;
						g.status = (use_cnt[slot] != '0) ? STS_NO : STS_YES;
					end
				end
				default: g.status = STS_BAD;
			endcase
			g.hw = hw_mark;
			return g;
		endfunction

		function void note_request(logic [OP_W-1:0] req_op, logic [KIND_W-1:0] kind,
				logic [SLOT_W-1:0] slot, logic [TYPE_W-1:0] vtype);
			expected_grants.push_back(predict_grant(req_op, kind, slot, vtype));
		endfunction

		function void check_grant(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] gs,
				logic [TYPE_W-1:0] gt, logic [HWP_W-1:0] hw);
			grant_t want;
			if (expected_grants.size() == 0) begin
				$error("result with no request outstanding: status %0d", st);
				errors++;
				return;
			end
			want = expected_grants.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				errors++;
			end
			if (gs !== want.slot) begin
				$error("granted_slot: expected %0d, got %0d", want.slot, gs);
				errors++;
			end
			if (gt !== want.vtype) begin
				$error("granted_type: expected %0d, got %0d", want.vtype, gt);
				errors++;
			end
			if (hw !== want.hw) begin
				$error("high_water: expected %0d, got %0d", want.hw, hw);
				errors++;
			end
			status_hits[want.status]++;
		endfunction
	endclass
endpackage

FILE: verif/refcounted_slot_allocator_tb.sv
`timescale 1ns / 100ps
// Top-level testbench of the reference-counted slot allocator: drives requests,
// collects results and checks them against the scoreboard in rsa_tb_pkg.
// Depends on rsa_pkg, rsa_tb_pkg and the refcounted_slot_allocator RTL.
module refcounted_slot_allocator_tb;
	import rsa_pkg::*;
	import rsa_tb_pkg::*;

	// Allocation is the slowest request. Even with every gap and stall at its
	// worst, the six hundred or so transactions of a run finish far inside this
	// bound, so hitting it means the block hung.
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASE_ITEMS     = 12;
	localparam int PRESSURE_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 10;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     op;
	logic [KIND_W-1:0]   operand_kind;
	logic [SLOT_W-1:0]   slot_index;
	logic [TYPE_W-1:0]   value_type;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   granted_slot;
	logic [TYPE_W-1:0]   granted_type;
	logic [HWP_W-1:0]    high_water;

	alloc_scoreboard sb;
	int              send_idle_pct;
	int              stall_pct;
	bit              hold_off;
	int              requests_sent;
	int              cycle_cnt;

	refcounted_slot_allocator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.operand_kind (operand_kind),
		.slot_index   (slot_index),
		.value_type   (value_type),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_slot (granted_slot),
		.granted_type (granted_type),
		.high_water   (high_water)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The receiver decides its ready at each falling edge. During a hold-off
	// it refuses everything, so the block's result stage fills and in_ready
	// drops while the sender keeps a transaction waiting.
	always @(negedge clk) begin
		out_ready = hold_off ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
	end

	// Every result transaction is checked at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_grant(status, granted_slot, granted_type, high_water);
		end
	end

	// Watchdog: a run that has not ended by the limit is a hang.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("refcounted_slot_allocator_tb: done, errors");
		$finish;
	end

	// Offers one request, starting at a falling edge, and returns at the
	// falling edge after the request was accepted. Valid stays high into the
	// next call, which either replaces the payload or lowers it for a gap.
	task automatic offer_request(input logic [OP_W-1:0] req_op,
			input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
			input logic [TYPE_W-1:0] vtype);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		op           = req_op;
		operand_kind = kind;
		slot_index   = slot;
		value_type   = vtype;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req_op, kind, slot, vtype);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	// Picks a slot that is probably held, so that acquire and release mostly
	// reach the count update instead of bouncing off a free slot.
	function automatic logic [SLOT_W-1:0] pick_held_slot();
		logic [SLOT_W-1:0] s;
		s = SLOT_W'($urandom_range(0, SLOTS - 1));
		if (sb.hw_mark == '0) return s;
		for (int tries = 0; tries < 8; tries++) begin
			s = SLOT_W'($urandom_range(0, int'(sb.hw_mark) - 1));
			if (sb.use_cnt[s] != '0) return s;
		end
		return s;
	endfunction

	// Mostly well-formed traffic on a small live set of temporaries; a tenth
	// is noise with any op, any kind and any slot, the unused op included.
	// Allocations slightly outnumber releases.
	task automatic random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			offer_request(OP_ALLOC, KIND_W'($urandom_range(0, 15)),
				SLOT_W'($urandom_range(0, 255)), TYPE_W'($urandom_range(0, 255)));
		end else if (r < 60) begin
			offer_request(OP_ACQUIRE, KIND_TEMP, pick_held_slot(),
				TYPE_W'($urandom_range(0, 255)));
		end else if (r < 90) begin
			offer_request(OP_RELEASE, KIND_TEMP, pick_held_slot(),
				TYPE_W'($urandom_range(0, 255)));
		end else begin
			offer_request(OP_W'($urandom_range(0, 3)), KIND_W'($urandom_range(0, 15)),
				SLOT_W'($urandom_range(0, 255)), TYPE_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		logic [SLOT_W-1:0] sat_slot;

		sb            = new();
		requests_sent = 0;
		hold_off      = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_ALLOC;
		operand_kind  = KIND_TEMP;
		slot_index    = '0;
		value_type    = '0;
		out_ready     = 1'b0;
		set_idling(0, 0);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, no idling. Allocations with extreme type codes, and
		// one whose ignored kind and slot fields are all ones.
		offer_request(OP_ALLOC, KIND_TEMP, 8'd0, 8'd0);
		offer_request(OP_ALLOC, KIND_TOP, 8'd255, 8'd255);
		offer_request(OP_ALLOC, KIND_TEMP, 8'd0, 8'hA5);
		// Acquire, then a release that leaves the slot held, then the one that frees
		// it, then release and acquire of the now free slot, then acquire of slot 255.
		offer_request(OP_ACQUIRE, KIND_TEMP, 8'd1, 8'd0);
		offer_request(OP_RELEASE, KIND_TEMP, 8'd1, 8'd0);
		offer_request(OP_RELEASE, KIND_TEMP, 8'd1, 8'd0);
		offer_request(OP_RELEASE, KIND_TEMP, 8'd1, 8'd0);
		offer_request(OP_ACQUIRE, KIND_TEMP, 8'd1, 8'd0);
		offer_request(OP_ACQUIRE, KIND_TEMP, 8'd255, 8'd255);
		// Operands that are not temporaries, known and unknown kinds alike.
		offer_request(OP_ACQUIRE, KIND_ARG, 8'd0, 8'd0);
		offer_request(OP_ACQUIRE, KIND_UNKNOWN, 8'd0, 8'd0);
		offer_request(OP_ACQUIRE, KIND_TOP, 8'd0, 8'd0);
		offer_request(OP_RELEASE, KIND_ARG, 8'd0, 8'd0);
		offer_request(OP_RELEASE, KIND_LAST_KNOWN, 8'd0, 8'd0);
		offer_request(OP_RELEASE, KIND_UNKNOWN, 8'd0, 8'd0);
		offer_request(OP_RELEASE, KIND_UNUSED, 8'd0, 8'd0);
		offer_request(OP_RELEASE, KIND_TOP, 8'd255, 8'd255);
		offer_request(OP_UNUSED, KIND_TEMP, 8'd0, 8'd0);
		// The freed slot is reused first; the high-water mark does not move.
		offer_request(OP_ALLOC, KIND_TEMP, 8'd0, 8'd7);
		offer_request(OP_RELEASE, KIND_TEMP, 8'd0, 8'd0);
		offer_request(OP_ALLOC, KIND_TEMP, 8'd0, 8'd9);

		// Random part in four idling mixes. The first also carries the long
		// output hold-off, counted in its own process from a rising edge so
		// that it never races the receiver's falling-edge decision.
		fork
			begin
				@(posedge clk);
				hold_off = 1'b1;
				repeat (PRESSURE_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
		join_none
		set_idling(0, 0);
		repeat (PHASE_ITEMS) random_request();
		set_idling(55, 0);
		repeat (PHASE_ITEMS) random_request();
		set_idling(0, 55);
		repeat (PHASE_ITEMS) random_request();
		set_idling(28, 28);
		repeat (PHASE_ITEMS) random_request();

		// Fill the whole table, then knock on it twice while it is full.
		while (!sb.table_full()) begin
			offer_request(OP_ALLOC, KIND_TEMP, 8'd0, TYPE_W'($urandom_range(0, 255)));
		end
		repeat (2) offer_request(OP_ALLOC, KIND_TEMP, 8'd0, TYPE_W'($urandom_range(0, 255)));

		// Count saturation: drive the slot handed out last up to its ceiling
		// and past it, then release it once so that it stays held.
		sat_slot = sb.last_slot;
		while (sb.use_cnt[sat_slot] != COUNT_MAX) begin
			offer_request(OP_ACQUIRE, KIND_TEMP, sat_slot, 8'd0);
		end
		repeat (2) offer_request(OP_ACQUIRE, KIND_TEMP, sat_slot, 8'd0);
		offer_request(OP_RELEASE, KIND_TEMP, sat_slot, 8'd0);
		repeat (4) random_request();
		in_valid = 1'b0;

		// Wait out every outstanding result, then wait on for DRAIN_CYCLES so that
		// any spurious extra result is still caught.
		while (sb.expected_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d requests; yes %0d, no %0d, bad %0d, full %0d, no release %0d.",
			requests_sent, sb.status_hits[STS_YES], sb.status_hits[STS_NO],
			sb.status_hits[STS_BAD], sb.status_hits[STS_FULL], sb.status_hits[STS_NOREL]);
		$display("Summary: %0d acquires at the ceiling, table filled, %0d-cycle stall.",
			sb.saturated, PRESSURE_CYCLES);
		if (sb.errors == 0) begin
			$display("refcounted_slot_allocator_tb: done, clean");
		end else begin
			$display("refcounted_slot_allocator_tb: done, errors");
		end
		$finish;
	end
endmodule
